### sv/tgu_pkg.sv
package tgu_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int TAN_WIDTH       = 18;
  localparam int FRAC_BITS       = 16;
  localparam int NORM_BITS       = 30;
  localparam int FIELD_COUNT     = 10;

  // Field slots of a queue entry, each DW bits wide
  localparam int F_E1X = 0;
  localparam int F_E1Y = 1;
  localparam int F_E1Z = 2;
  localparam int F_E2X = 3;
  localparam int F_E2Y = 4;
  localparam int F_E2Z = 5;
  localparam int F_D1U = 6;
  localparam int F_D1V = 7;
  localparam int F_D2U = 8;
  localparam int F_D2V = 9;

endpackage

### sv/tgu_front.sv
module tgu_front #(
  parameter int CW = tgu_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [CW-1:0]                pos_x,
  input  logic signed [CW-1:0]                pos_y,
  input  logic signed [CW-1:0]                pos_z,
  input  logic signed [CW-1:0]                tex_u,
  input  logic signed [CW-1:0]                tex_v,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [tgu_pkg::FIELD_COUNT*(CW+1)-1:0] push_data
);

  localparam int DW = CW + 1;

  logic [1:0]           count;
  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] t0 [2];
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] t1 [2];
  logic signed [CW-1:0] pin [3];
  logic signed [CW-1:0] tin [2];
  logic                 third;
  logic                 accept;

  assign pin[0] = pos_x;
  assign pin[1] = pos_y;
  assign pin[2] = pos_z;
  assign tin[0] = tex_u;
  assign tin[1] = tex_v;

  assign third      = (count >= 2'd2);
  assign in_ready   = !third || push_ready;
  assign push_valid = in_valid && third;
  assign accept     = in_valid && in_ready;

  // Edge and texture deltas relative to the first corner
  always_comb begin
    push_data = '0;
    for (int i = 0; i < 3; i++) begin
      push_data[(tgu_pkg::F_E1X + i)*DW +: DW] =
        DW'($signed({p1[i][CW-1], p1[i]}) - $signed({p0[i][CW-1], p0[i]}));
      push_data[(tgu_pkg::F_E2X + i)*DW +: DW] =
        DW'($signed({pin[i][CW-1], pin[i]}) - $signed({p0[i][CW-1], p0[i]}));
    end
    for (int i = 0; i < 2; i++) begin
      push_data[(tgu_pkg::F_D1U + i)*DW +: DW] =
        DW'($signed({t1[i][CW-1], t1[i]}) - $signed({t0[i][CW-1], t0[i]}));
      push_data[(tgu_pkg::F_D2U + i)*DW +: DW] =
        DW'($signed({tin[i][CW-1], tin[i]}) - $signed({t0[i][CW-1], t0[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      count <= third ? 2'd0 : count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count == 2'd0) begin
      p0 <= pin;
      t0 <= tin;
    end
    if (accept && count == 2'd1) begin
      p1 <= pin;
      t1 <= tin;
    end
  end

endmodule

### sv/tgu_queue.sv
module tgu_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = tgu_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CNTW-1:0]  fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNTW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

### sv/tgu_back.sv
module tgu_back #(
  parameter int CW = tgu_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pop_valid,
  output logic                                   pop_ready,
  input  logic [tgu_pkg::FIELD_COUNT*(CW+1)-1:0] pop_data,
  output logic signed [tgu_pkg::TAN_WIDTH-1:0]   tangent_x,
  output logic signed [tgu_pkg::TAN_WIDTH-1:0]   tangent_y,
  output logic signed [tgu_pkg::TAN_WIDTH-1:0]   tangent_z,
  output logic                                   degenerate,
  output logic                                   out_valid,
  input  logic                                   out_ready
);

  localparam int DW   = CW + 1;
  localparam int PW   = 2*DW + 1;
  localparam int ND   = (DW + 3) / 4;
  localparam int DCW  = $clog2(ND);
  localparam int NB   = tgu_pkg::NORM_BITS;
  localparam int TW   = tgu_pkg::TAN_WIDTH;
  localparam int FB   = tgu_pkg::FRAC_BITS;
  localparam int NUMW = NB + FB + 2;
  localparam int LW   = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_TERM, S_MUL, S_ACC, S_CHECK, S_NORM, S_SQ, S_SQRT,
    S_DIV_INIT, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [tgu_pkg::FIELD_COUNT*DW-1:0] ent;
  logic signed [DW-1:0]   f [tgu_pkg::FIELD_COUNT];
  logic [2:0]             k;
  logic [DCW-1:0]         dc;
  logic signed [PW-1:0]   t;
  logic [ND*4-1:0]        bmag;
  logic                   bsign;
  logic signed [PW-1:0]   acc [4];
  logic [PW-1:0]          m [3];
  logic [2:0]             sg;
  logic                   degen;
  logic [1:0]             j;
  logic [63:0]            sacc;
  logic [63:0]            srem;
  logic [63:0]            res;
  logic [63:0]            bitr;
  logic [LW-1:0]          len;
  logic [LW:0]            r;
  logic [TW-1:0]          nsh;
  logic [TW-1:0]          q;
  logic [4:0]             qc;
  logic signed [TW-1:0]   tan [3];

  logic signed [DW-1:0]   a_sel;
  logic signed [DW-1:0]   b_sel;
  logic [1:0]             idx;
  logic signed [PW-1:0]   a_ext;
  logic [3:0]             dig;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   tsg;
  logic [PW-1:0]          mor;
  logic [NB-1:0]          mmj;
  logic [63:0]            ssum;
  logic [63:0]            trial;
  logic [NUMW-1:0]        num;
  logic [LW:0]            rt;
  logic                   ge;
  logic [TW-1:0]          q_next;

  always_comb begin
    for (int i = 0; i < tgu_pkg::FIELD_COUNT; i++) begin
      f[i] = $signed(ent[i*DW +: DW]);
    end
  end

  // Term order: det gets d1u*d2v - d2u*d1v, w[i] gets d2v*e1[i] - d1v*e2[i]
  always_comb begin
    idx = k[2:1] - 2'd1;
    case (k)
      3'd0:    a_sel = f[tgu_pkg::F_D1U];
      3'd1:    a_sel = f[tgu_pkg::F_D2U];
      default: a_sel = k[0] ? f[tgu_pkg::F_E2X + 32'(idx)] : f[tgu_pkg::F_E1X + 32'(idx)];
    endcase
    b_sel = k[0] ? f[tgu_pkg::F_D1V] : f[tgu_pkg::F_D2V];
  end

  assign a_ext = PW'(a_sel);
  assign dig   = bmag[ND*4-1 -: 4];
  assign prod  = a_ext * $signed({1'b0, dig});
  assign tsg   = bsign ? -t : t;
  assign mor   = m[0] | m[1] | m[2];
  assign mmj   = m[j][NB-1:0];
  assign ssum  = sacc + 64'(mmj) * 64'(mmj);
  assign trial = res + bitr;
  assign num   = {2'b00, mmj, {FB{1'b0}}} + NUMW'(len >> 1);
  assign rt    = {r[LW-1:0], nsh[TW-1]};
  assign ge    = (rt >= {1'b0, len});
  assign q_next = {q[TW-2:0], ge};

  assign pop_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            ent   <= pop_data;
            k     <= 3'd0;
            for (int i = 0; i < 4; i++) acc[i] <= '0;
            state <= S_TERM;
          end
        end
        S_TERM: begin
          bmag  <= (ND*4)'(b_sel[DW-1] ? DW'(-b_sel) : DW'(b_sel));
          bsign <= b_sel[DW-1] ^ k[0];
          t     <= '0;
          dc    <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          t    <= (t <<< 4) + prod;
          bmag <= bmag << 4;
          dc   <= dc + 1'b1;
          if (dc == DCW'(ND - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc[k[2:1]] <= acc[k[2:1]] + tsg;
          if (k == 3'd7) begin
            state <= S_CHECK;
          end else begin
            k     <= k + 3'd1;
            state <= S_TERM;
          end
        end
        S_CHECK: begin
          if (acc[0] == '0 || (acc[1] == '0 && acc[2] == '0 && acc[3] == '0)) begin
            degen <= 1'b1;
            for (int i = 0; i < 3; i++) tan[i] <= '0;
            state <= S_OUT;
          end else begin
            degen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              m[i]  <= acc[i+1][PW-1] ? PW'(-acc[i+1]) : PW'(acc[i+1]);
              sg[i] <= acc[i+1][PW-1] ^ acc[0][PW-1];
            end
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Bring the largest magnitude to exactly NB significant bits
          if ((mor >> (NB + 4)) != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 4;
          end else if ((mor >> NB) != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if ((mor >> (NB - 5)) == '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 4;
          end else if (!mor[NB-1]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            j     <= 2'd0;
            sacc  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sacc <= ssum;
          if (j == 2'd2) begin
            srem  <= ssum;
            res   <= '0;
            bitr  <= 64'd1 << 62;
            state <= S_SQRT;
          end else begin
            j <= j + 2'd1;
          end
        end
        S_SQRT: begin
          if (srem >= trial) begin
            srem <= srem - trial;
            res  <= (res >> 1) + bitr;
          end else begin
            res  <= res >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr[0]) begin
            state <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          r     <= (LW+1)'(num[NUMW-1:TW]);
          nsh   <= num[TW-1:0];
          q     <= '0;
          qc    <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          r   <= ge ? rt - {1'b0, len} : rt;
          q   <= q_next;
          nsh <= nsh << 1;
          qc  <= qc + 5'd1;
          if (qc == 5'(TW - 1)) begin
            tan[j] <= sg[j] ? -$signed(q_next) : $signed(q_next);
            if (j == 2'd2) begin
              state <= S_OUT;
            end else begin
              j     <= j + 2'd1;
              state <= S_DIV_INIT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            tangent_x  <= tan[0];
            tangent_y  <= tan[1];
            tangent_z  <= tan[2];
            degenerate <= degen;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Latch the root as divisor and restart the component walk at x
      if (state == S_SQRT && bitr[0]) begin
        len <= (trial <= srem) ? LW'((res >> 1) + bitr) : LW'(res >> 1);
        j   <= 2'd0;
        qc  <= '0;
      end
    end
  end

endmodule

### sv/triangle_tangent_unit.sv
// From the third corner, a triangle passes the digit-serial multiplier, the normalizing
// shifter, the bitwise square root and the divider. The sequencer takes a new triangle
// from the two-entry queue only while idle. Corners are taken one per cycle, the third
// only while the queue has room. Reset (rst, synchronous) clears the corner count, the
// queue and the sequencer; held corners need no clearing.
module triangle_tangent_unit #(
  parameter int COORD_WIDTH = tgu_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [COORD_WIDTH-1:0]        pos_x,
  input  logic signed [COORD_WIDTH-1:0]        pos_y,
  input  logic signed [COORD_WIDTH-1:0]        pos_z,
  input  logic signed [COORD_WIDTH-1:0]        tex_u,
  input  logic signed [COORD_WIDTH-1:0]        tex_v,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  output logic signed [tgu_pkg::TAN_WIDTH-1:0] tangent_x,
  output logic signed [tgu_pkg::TAN_WIDTH-1:0] tangent_y,
  output logic signed [tgu_pkg::TAN_WIDTH-1:0] tangent_z,
  output logic                                 degenerate,
  output logic                                 out_valid,
  input  logic                                 out_ready
);

  localparam int EW = tgu_pkg::FIELD_COUNT * (COORD_WIDTH + 1);

  logic          push_valid;
  logic          push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [EW-1:0] pop_data;

  tgu_front #(.CW(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tgu_queue #(.WIDTH(EW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tgu_back #(.CW(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .tangent_x  (tangent_x),
    .tangent_y  (tangent_y),
    .tangent_z  (tangent_z),
    .degenerate (degenerate),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
